>>> design/fls_pkg.sv
// Package for the FNV-1a linear-probing uniqueness set.
// Hash constants, status codes, result type and capacity limits.
// No dependencies.
package fls_pkg;

  localparam logic [31:0] HASH_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] HASH_PRIME = 32'h0100_0193;

  localparam logic [1:0] ST_NEW = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_OFF = 2'd2;

  localparam int          LG_W     = 5;
  localparam logic [4:0]  LG_MIN   = 5'd6;
  localparam logic [4:0]  LG_MAX   = 5'd16;
  localparam logic [4:0]  LG_RESET = 5'd16;
  // capacity word: holds 1 << LG_MAX
  localparam int          CAP_W    = 17;
  localparam int          CNT_W    = 16;

  typedef struct packed {
    logic [1:0]       status;
    logic             still_unique;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage

>>> design/fnv1a_linear_probe_uniqueness_set.sv
// Top level of the FNV-1a linear-probing uniqueness set.
// Uses fls_pkg, fls_hash_front, fls_fifo and fls_probe_back.
//
// Input queue side: drive in_value_byte / in_last_byte with in_push; an
// item is taken when in_push is high and in_full is low. Bytes stream at one
// per cycle while in_full is low; only an in_last_byte item gives a result.
// Result queue side: while out_empty is low the oldest result sits on
// out_insert_status / out_still_unique / out_stored_count; out_pop takes it.
// Config: cfg_table_size_log2 is written on cfg_valid (cfg_ready is tied
// high); write it only while the block is idle.
// Flow: the finished hash goes through the hash queue to the probe engine,
// and its result through the result queue to the out_ ports; a value that
// is not tracked skips the probe. The probe engine reads one slot at a time
// through the single read port of the slot RAM; values that are not
// tracked do not read it.
// Reset: a clearing pass zeroes every slot of the slot table, with
// in_full held high; config writes are still taken.
// Stall: when out_pop is withheld the two-entry result queue fills, the
// probe engine waits, then the two-entry hash queue fills and in_full rises.
module fnv1a_linear_probe_uniqueness_set
  import fls_pkg::*;
#(
  parameter int MAX_SLOTS = 65536
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  input  logic [7:0]      in_value_byte,
  input  logic            in_last_byte,
  output logic            in_full,
  input  logic            out_pop,
  output logic            out_empty,
  output logic [1:0]      out_insert_status,
  output logic            out_still_unique,
  output logic [15:0]     out_stored_count,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [LG_W-1:0] cfg_table_size_log2
);

  logic [LG_W-1:0] lg_r;
  logic            clearing;
  logic            hq_push, hq_pop, hq_full, hq_empty;
  logic [31:0]     hq_wdata, hq_rdata;
  logic            res_push, res_full;
  result_t         res_wdata, res_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_r <= LG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lg_r <= cfg_table_size_log2;
    end
  end

  fls_hash_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_value_byte (in_value_byte),
    .in_last_byte  (in_last_byte),
    .stall         (clearing || hq_full),
    .in_full       (in_full),
    .hq_push       (hq_push),
    .hq_data       (hq_wdata)
  );

  fls_fifo #(
    .WIDTH (32),
    .DEPTH (2)
  ) u_hash_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (hq_push),
    .wr_data (hq_wdata),
    .pop     (hq_pop),
    .rd_data (hq_rdata),
    .full    (hq_full),
    .empty   (hq_empty)
  );

  fls_probe_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .lg       (lg_r),
    .hq_empty (hq_empty),
    .hq_data  (hq_rdata),
    .hq_pop   (hq_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_wdata),
    .clearing (clearing)
  );

  fls_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wdata),
    .pop     (out_pop),
    .rd_data (res_rdata),
    .full    (res_full),
    .empty   (out_empty)
  );

  assign out_insert_status = res_rdata.status;
  assign out_still_unique  = res_rdata.still_unique;
  assign out_stored_count  = res_rdata.count;

endmodule

>>> design/fls_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module fls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/fls_fifo.sv
// Small register FIFO with full/empty flags, data shown at the head.
// No dependencies.
module fls_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> design/fls_hash_front.sv
// Front end: takes value bytes, folds them into the FNV-1a hash and
// hands the finished hash on at the last byte. Uses fls_pkg.
module fls_hash_front
  import fls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_value_byte,
  input  logic        in_last_byte,
  input  logic        stall,
  output logic        in_full,
  output logic        hq_push,
  output logic [31:0] hq_data
);

  logic [31:0] hash_r, hash_nxt;
  logic [31:0] mixed;
  logic [31:0] prod;
  logic        accept;

  assign in_full = stall;
  assign accept  = in_push && !stall;
  assign mixed   = hash_r ^ {24'd0, in_value_byte};
  assign prod    = mixed * HASH_PRIME;
  assign hq_push = accept && in_last_byte;
  assign hq_data = prod;

  always_comb begin
    hash_nxt = hash_r;
    if (accept) begin
      hash_nxt = in_last_byte ? HASH_BASIS : prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= HASH_BASIS;
    end else begin
      hash_r <= hash_nxt;
    end
  end

endmodule

>>> design/fls_probe_back.sv
// Back end: clears the slot table after reset, then probes it linearly for
// each queued hash it still tracks; emits one result per hash. Uses fls_pkg and fls_ram.
module fls_probe_back
  import fls_pkg::*;
#(
  parameter int MAX_SLOTS = 65536
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [LG_W-1:0] lg,
  input  logic            hq_empty,
  input  logic [31:0]     hq_data,
  output logic            hq_pop,
  input  logic            res_full,
  output logic            res_push,
  output result_t         res_data,
  output logic            clearing
);

  localparam int AW = $clog2(MAX_SLOTS);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic             uniq_r, uniq_nxt;
  logic [CAP_W-1:0] start_r, start_nxt;
  logic [CAP_W-1:0] i_r, i_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [31:0]      word_r, word_nxt;

  logic [LG_W-1:0]  lg_c;
  logic [CAP_W-1:0] cap, mask, half;
  logic [CAP_W-1:0] i_inc, start_h;
  logic [CAP_W:0]   sum;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, ram_rdata;

  always_comb begin
    lg_c = lg;
    if (lg < LG_MIN) lg_c = LG_MIN;
    if (lg > LG_MAX) lg_c = LG_MAX;
    cap = CAP_W'(1) << lg_c;
    if (cap > CAP_W'(MAX_SLOTS)) cap = CAP_W'(MAX_SLOTS);
  end

  assign mask     = cap - 1'b1;
  assign half     = cap >> 1;
  assign i_inc    = i_r + 1'b1;
  assign sum      = {1'b0, start_r} + {1'b0, i_inc};
  assign start_h  = hq_data[CAP_W-1:0] & mask;
  assign clearing = (state_r == S_CLEAR);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    occ_nxt   = occ_r;
    uniq_nxt  = uniq_r;
    start_nxt = start_r;
    i_nxt     = i_r;
    pos_nxt   = pos_r;
    word_nxt  = word_r;
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = word_r;
    ram_raddr = pos_r;
    hq_pop    = 1'b0;
    res_push  = 1'b0;
    res_data  = '{status: ST_OFF, still_unique: uniq_r, count: occ_r};
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(MAX_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!hq_empty && !res_full) begin
          hq_pop = 1'b1;
          if (!uniq_r) begin
            res_push = 1'b1;
          end else if ({1'b0, occ_r} >= half) begin
            uniq_nxt              = 1'b0;
            res_push              = 1'b1;
            res_data.still_unique = 1'b0;
          end else begin
            start_nxt = start_h;
            pos_nxt   = AW'(start_h);
            ram_raddr = AW'(start_h);
            word_nxt  = hq_data | 32'd1;
            i_nxt     = '0;
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        priority if (ram_rdata == '0) begin
          ram_we    = 1'b1;
          occ_nxt   = occ_r + 1'b1;
          res_push  = 1'b1;
          res_data  = '{status: ST_NEW, still_unique: 1'b1, count: occ_r + 1'b1};
          state_nxt = S_IDLE;
        end else if (ram_rdata == word_r || i_inc == cap) begin
          uniq_nxt  = 1'b0;
          res_push  = 1'b1;
          res_data  = '{status: ST_DUP, still_unique: 1'b0, count: occ_r};
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_inc;
          pos_nxt   = AW'(sum & {1'b0, mask});
          ram_raddr = AW'(sum & {1'b0, mask});
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      occ_r   <= '0;
      uniq_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      occ_r   <= occ_nxt;
      uniq_r  <= uniq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    i_r     <= i_nxt;
    pos_r   <= pos_nxt;
    word_r  <= word_nxt;
  end

  fls_ram #(
    .WIDTH (32),
    .DEPTH (MAX_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> design/fls_checker.sv
// Port-level checks for the uniqueness set, bound to the top level.
// Uses fls_pkg.
module fls_checker
  import fls_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_full,
  input logic            out_empty,
  input logic [1:0]      out_insert_status,
  input logic            out_still_unique,
  input logic [15:0]     out_stored_count
);

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (out_empty && in_full))
    else $error("queues not held after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_insert_status == ST_NEW || out_insert_status == ST_DUP ||
                    out_insert_status == ST_OFF))
    else $error("illegal insert status");

  a_new_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_insert_status == ST_NEW) |->
      (out_still_unique && out_stored_count != 16'd0))
    else $error("new item without unique flag or count");

  a_dup_not_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_insert_status == ST_DUP) |-> !out_still_unique)
    else $error("duplicate item left unique flag set");

endmodule

bind fnv1a_linear_probe_uniqueness_set fls_checker u_fls_checker (.*);
